@@ hw/rtl/lpsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lpsd_pkg;

    localparam int unsigned BRIGHT_W = 8;
    localparam int unsigned SLOT_W   = 8;
    localparam int unsigned LED_W    = 6;
    localparam int unsigned GRPOUT_W = 3;
    localparam int unsigned LANES    = 8;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic              half;
        logic [SLOT_W-1:0] slot;
    } t_tick_cmd;

    typedef struct packed {
        logic                last;
        logic [SLOT_W-1:0]   slot;
        logic [GRPOUT_W-1:0] grp;
        logic [LANES-1:0]    slice_byte;
    } t_slice;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_front_state;

endpackage

`default_nettype wire

@@ hw/rtl/lpsd_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpsd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/lpsd_cmd_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpsd_cmd_fifo
    import lpsd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_tick_cmd i_cmd,
    input  wire logic      i_pop,
    output logic           o_full,
    output logic           o_valid,
    output t_tick_cmd      o_cmd
);

    t_tick_cmd  r_head;
    t_tick_cmd  r_second;
    logic [1:0] r_occ;
    logic [1:0] w_after_pop;

    assign o_full  = (r_occ == 2'd2);
    assign o_valid = (r_occ != 2'd0);
    assign o_cmd   = r_head;

    assign w_after_pop = r_occ - {1'b0, i_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 2'd0;
        end else begin
            r_occ <= w_after_pop + {1'b0, i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop && r_occ == 2'd2) begin
            r_head <= r_second;
        end
        if (i_push) begin
            if (w_after_pop == 2'd0) begin
                r_head <= i_cmd;
            end else begin
                r_second <= i_cmd;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lpsd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpsd_front
    import lpsd_pkg::*;
#(
    parameter int unsigned LED_COUNT = 64,
    parameter int unsigned AW        = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic                i_op,
    input  wire logic [LED_W-1:0]    i_led,
    input  wire logic [BRIGHT_W-1:0] i_bright,
    input  wire logic                i_done,
    input  wire logic [SLOT_W-1:0]   i_pwm_top,
    input  wire logic                i_back_idle,
    input  wire logic                i_cmd_full,
    output logic                     o_cmd_push,
    output t_tick_cmd                o_cmd,
    output logic [LANES-1:0]         o_wr_en,
    output logic [AW-1:0]            o_wr_addr,
    output logic [BRIGHT_W-1:0]      o_wr_data
);

    localparam int unsigned GW = AW - 1;

    t_front_state      r_state;
    t_front_state      n_state;
    logic [AW-1:0]     r_clr_addr;
    logic              r_fsel;
    logic              n_fsel;
    logic              r_bready;
    logic              n_bready;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic [SLOT_W:0]   w_next;
    logic              w_wrap;
    logic              w_swap;
    logic              w_accept;
    logic              w_in_range;

    assign w_next     = {1'b0, r_slot} + {{SLOT_W{1'b0}}, 1'b1};
    assign w_wrap     = (w_next > {1'b0, i_pwm_top});
    assign w_swap     = w_wrap && r_bready;
    assign w_accept   = i_valid && o_ready;
    assign w_in_range = (int'(i_led) < LED_COUNT);

    always_comb begin
        case (r_state)
            ST_RUN: begin
                if (i_op == OP_PIXEL) begin
                    o_ready = 1'b1;
                end else begin
                    o_ready = !i_cmd_full && (!w_swap || i_back_idle);
                end
            end
            default: o_ready = 1'b0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_fsel   = r_fsel;
        n_bready = r_bready;
        n_slot   = r_slot;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == {AW{1'b1}}) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_accept) begin
                    if (i_op == OP_PIXEL) begin
                        n_bready = i_done;
                    end else begin
                        n_slot = w_wrap ? '0 : w_next[SLOT_W-1:0];
                        if (w_swap) begin
                            n_fsel   = !r_fsel;
                            n_bready = 1'b0;
                        end
                    end
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_fsel     <= 1'b0;
            r_bready   <= 1'b0;
            r_slot     <= '0;
        end else begin
            r_state    <= n_state;
            r_fsel     <= n_fsel;
            r_bready   <= n_bready;
            r_slot     <= n_slot;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + {{(AW-1){1'b0}}, 1'b1};
            end
        end
    end

    assign o_cmd_push = w_accept && (i_op == OP_TICK);
    assign o_cmd.half = n_fsel;
    assign o_cmd.slot = n_slot;

    always_comb begin
        o_wr_en   = '0;
        o_wr_addr = {!r_fsel, GW'(i_led[LED_W-1:3])};
        o_wr_data = i_bright;
        if (r_state == ST_CLEAR) begin
            o_wr_en   = '1;
            o_wr_addr = r_clr_addr;
            o_wr_data = '0;
        end else if (w_accept && i_op == OP_PIXEL && w_in_range) begin
            o_wr_en = LANES'(1) << i_led[2:0];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lpsd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpsd_back
    import lpsd_pkg::*;
#(
    parameter int unsigned GROUP_COUNT = 8,
    parameter int unsigned AW          = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cmd_valid,
    output logic                                o_cmd_pop,
    input  wire t_tick_cmd                      i_cmd,
    output logic [AW-1:0]                       o_rd_addr,
    input  wire logic [LANES-1:0][BRIGHT_W-1:0] i_rd_data,
    output logic                                o_busy,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output t_slice                              o_slice
);

    localparam int unsigned GW = AW - 1;

    logic              r_active;
    logic              r_half;
    logic [GW-1:0]     r_grp;
    logic [SLOT_W-1:0] r_slot;
    logic              r_inflight;
    t_slice            r_meta;
    t_slice            r_head;
    t_slice            r_second;
    logic [1:0]        r_occ;
    logic [1:0]        w_used;
    logic [1:0]        w_after_pop;
    logic              w_pop;
    logic              w_issue;
    t_slice            w_new;

    assign o_busy    = r_active;
    assign o_cmd_pop = !r_active && i_cmd_valid;
    assign o_rd_addr = {r_half, r_grp};

    assign w_pop       = (r_occ != 2'd0) && i_ready;
    assign w_used      = r_occ + {1'b0, r_inflight};
    assign w_after_pop = r_occ - {1'b0, w_pop};
    assign w_issue     = r_active && ((w_used < 2'd2) || (w_used == 2'd2 && w_pop));

    always_comb begin
        w_new = r_meta;
        for (int k = 0; k < LANES; k++) begin
            w_new.slice_byte[k] = (i_rd_data[k] > r_meta.slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_inflight <= 1'b0;
            r_occ      <= 2'd0;
        end else begin
            r_inflight <= w_issue;
            r_occ      <= w_after_pop + {1'b0, r_inflight};
            if (o_cmd_pop) begin
                r_active <= 1'b1;
            end else if (w_issue && r_grp == '0) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_half <= i_cmd.half;
            r_slot <= i_cmd.slot;
            r_grp  <= GW'(GROUP_COUNT - 1);
        end else if (w_issue) begin
            r_grp <= r_grp - {{(GW-1){1'b0}}, 1'b1};
        end
        if (w_issue) begin
            r_meta.last       <= (r_grp == '0);
            r_meta.slot       <= r_slot;
            r_meta.grp        <= GRPOUT_W'(r_grp);
            r_meta.slice_byte <= '0;
        end
        if (w_pop && r_occ == 2'd2) begin
            r_head <= r_second;
        end
        if (r_inflight) begin
            if (w_after_pop == 2'd0) begin
                r_head <= w_new;
            end else begin
                r_second <= w_new;
            end
        end
    end

    assign o_valid = (r_occ != 2'd0);
    assign o_slice = r_head;

endmodule

`default_nettype wire

@@ hw/rtl/led_pwm_slice_driver.sv @@
// Channel   Dir  Handshake                tdata (low bit up)                  Side bits
// s_axis    in   tvalid/tready            led_index[5:0] brightness[13:6]     tuser=operation
//                                                                             tlast=picture_done
// m_axis    out  tvalid/tready            slice_byte[7:0] group_index[10:8]   tlast=last_of_slice
//                                         slot_number[18:11]
// cfg       in   we (no wait)             pwm_top[7:0]                        -
//
// Pixel write: never stalled once running. Tick: queued for the back, then ceil(LED_COUNT/8)
// bytes at one per cycle while the output has room (single read port of the lane RAMs); with
// the back idle, the first byte passes the command queue, the back, RAM and output registers.
// Reset clears all 2^(GW+1) RAM addresses, GW = max(1, ceil(log2(groups))), 16 at 64 LEDs,
// no input taken. A swapping tick waits until earlier ticks are all read; ticks also stall
// while two wait between front and back. Two finished bytes wait at the output.
`timescale 1ns / 1ps
`default_nettype none

module led_pwm_slice_driver
    import lpsd_pkg::*;
#(
    parameter int unsigned LED_COUNT = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // led_index, brightness, zero pad
    input  wire logic        i_s_axis_tuser,  // operation
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [23:0] o_m_axis_tdata,  // slice_byte, group_index, slot_number, zero pad
    output logic             o_m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata
);

    localparam int unsigned GROUP_COUNT = (LED_COUNT + 7) / 8;
    localparam int unsigned GW          = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int unsigned AW          = GW + 1;
    localparam int unsigned DEPTH       = 1 << AW;

    logic [SLOT_W-1:0]               r_pwm_top;
    logic                            w_cmd_push;
    t_tick_cmd                       w_cmd_in;
    logic                            w_cmd_pop;
    logic                            w_cmd_full;
    logic                            w_cmd_valid;
    t_tick_cmd                       w_cmd_head;
    logic                            w_back_busy;
    logic [LANES-1:0]                w_wr_en;
    logic [AW-1:0]                   w_wr_addr;
    logic [BRIGHT_W-1:0]             w_wr_data;
    logic [AW-1:0]                   w_rd_addr;
    logic [LANES-1:0][BRIGHT_W-1:0]  w_rd_data;
    t_slice                          w_slice;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_top <= 8'hFF;
        end else if (i_cfg_we) begin
            r_pwm_top <= i_cfg_wdata;
        end
    end

    lpsd_front #(
        .LED_COUNT(LED_COUNT),
        .AW       (AW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_op       (i_s_axis_tuser),
        .i_led      (i_s_axis_tdata[5:0]),
        .i_bright   (i_s_axis_tdata[13:6]),
        .i_done     (i_s_axis_tlast),
        .i_pwm_top  (r_pwm_top),
        .i_back_idle(!w_cmd_valid && !w_back_busy),
        .i_cmd_full (w_cmd_full),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd_in),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data)
    );

    lpsd_cmd_fifo u_cmd_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_cmd_push),
        .i_cmd  (w_cmd_in),
        .i_pop  (w_cmd_pop),
        .o_full (w_cmd_full),
        .o_valid(w_cmd_valid),
        .o_cmd  (w_cmd_head)
    );

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        lpsd_ram #(
            .WIDTH(BRIGHT_W),
            .DEPTH(DEPTH)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (w_wr_en[k]),
            .i_waddr(w_wr_addr),
            .i_wdata(w_wr_data),
            .i_raddr(w_rd_addr),
            .o_rdata(w_rd_data[k])
        );
    end

    lpsd_back #(
        .GROUP_COUNT(GROUP_COUNT),
        .AW         (AW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_cmd_valid),
        .o_cmd_pop  (w_cmd_pop),
        .i_cmd      (w_cmd_head),
        .o_rd_addr  (w_rd_addr),
        .i_rd_data  (w_rd_data),
        .o_busy     (w_back_busy),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_slice    (w_slice)
    );

    assign o_m_axis_tdata = {5'b0, w_slice.slot, w_slice.grp, w_slice.slice_byte};
    assign o_m_axis_tlast = w_slice.last;

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_push |-> !w_cmd_full)
        else $error("tick command pushed into full queue");

    a_reset_blocks_input: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("input taken right after reset");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("tick command popped from empty queue");

    a_no_write_during_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en != '0) && w_back_busy |-> w_wr_addr[AW-1] != w_rd_addr[AW-1])
        else $error("picture write hits the half being shown");
`endif

endmodule

`default_nettype wire
